// ===== hdl/nqm_pkg.sv =====
// ----------------------------------------------------------------------------
// nqm_pkg
// Shared widths and types for the normalized quaternion multiply unit.
// ----------------------------------------------------------------------------
package nqm_pkg;

	localparam int FRAC_BITS  = 14;
	localparam int COMP_WIDTH = 16;

	localparam int NUM_COMP = 4;
	localparam int NUM_LANE = 2 * NUM_COMP;

	// squares and sums of squares of component magnitudes
	localparam int SQ_W = 2 * COMP_WIDTH - 1;
	localparam int S_W  = 2 * COMP_WIDTH + 1;

	// quotient c^2 * 2^(2F+2) / S never exceeds 2^(2F+2)
	localparam int Q_W  = 2 * FRAC_BITS + 3;
	localparam int R_W  = SQ_W + 2 * FRAC_BITS + 2;

	// integer square root of the quotient
	localparam int M_W   = FRAC_BITS + 2;
	localparam int RAD_W = 2 * M_W;

	// unit components and their products
	localparam int NW    = FRAC_BITS + 2;
	localparam int PW    = 2 * NW;
	localparam int ACC_W = PW + 2;

	localparam int LANE_ST = Q_W + M_W + 1;
	localparam int PIPE_ST = LANE_ST + 5;

	localparam int IN_W      = NUM_LANE * COMP_WIDTH;
	localparam int OUT_W     = NUM_COMP * COMP_WIDTH;
	localparam int IN_DATA_W  = 8 * ((IN_W + 7) / 8);
	localparam int OUT_DATA_W = 8 * ((OUT_W + 7) / 8);

	typedef logic [COMP_WIDTH-1:0] comp_t;
	typedef logic signed [NW-1:0] unit_t;

	typedef struct packed {
		logic neg;
		logic zero;
		logic scalar;
	} lane_ctl_t;

endpackage

// ===== hdl/nqm_norm_lane.sv =====
// ----------------------------------------------------------------------------
// nqm_norm_lane
// One component lane: c^2 * 2^(2F+2) / S by restoring division, one quotient
// bit a stage, then an integer square root one bit a stage, then rounding.
// ----------------------------------------------------------------------------
module nqm_norm_lane (
	input  logic                                clk,
	input  logic [nqm_pkg::LANE_ST-1:0]         en,
	input  logic [nqm_pkg::SQ_W-1:0]            sq_in,
	input  logic [nqm_pkg::S_W-1:0]             sum_in,
	input  nqm_pkg::lane_ctl_t                  ctl_in,
	output nqm_pkg::unit_t                      unit
);

	localparam int QW = nqm_pkg::Q_W;
	localparam int MW = nqm_pkg::M_W;
	localparam int SW = nqm_pkg::S_W;
	localparam int CTL_ST = QW + MW;

	logic [nqm_pkg::R_W-1:0] r_full;
	assign r_full = {sq_in, {(2 * nqm_pkg::FRAC_BITS + 2){1'b0}}};

	// division stages
	logic [SW-1:0] rem_in [QW];
	logic [QW-1:0] dq_in  [QW];
	logic [SW-1:0] sum_di [QW];
	logic [SW-1:0] rem_s  [QW];
	logic [QW-1:0] dq_s   [QW];
	logic [SW-1:0] sum_s  [QW];

	nqm_pkg::lane_ctl_t ctl_s [CTL_ST];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ctl_s[0] <= ctl_in;
		end
		for (int k = 1; k < CTL_ST; k++) begin
			if (en[k]) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [SW:0] trial;
		logic [SW:0] diff;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in[k] = SW'(r_full[nqm_pkg::R_W-1:QW]);
			assign dq_in[k]  = r_full[QW-1:0];
			assign sum_di[k] = sum_in;
		end else begin : g_next
			assign rem_in[k] = rem_s[k-1];
			assign dq_in[k]  = dq_s[k-1];
			assign sum_di[k] = sum_s[k-1];
		end

		always_comb begin
			trial = {rem_in[k], dq_in[k][QW-1]};
			diff  = trial - {1'b0, sum_di[k]};
			ge    = (trial >= {1'b0, sum_di[k]});
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= ge ? diff[SW-1:0] : trial[SW-1:0];
				dq_s[k]  <= {dq_in[k][QW-2:0], ge};
				sum_s[k] <= sum_di[k];
			end
		end
	end

	// square root stages, two radicand bits each
	logic [MW-1:0]              rt_in  [MW];
	logic [MW:0]                sr_in  [MW];
	logic [nqm_pkg::RAD_W-1:0]  rad_in [MW];
	logic [MW-1:0]              rt_s   [MW];
	logic [MW:0]                sr_s   [MW];
	logic [nqm_pkg::RAD_W-1:0]  rad_s  [MW];

	for (genvar j = 0; j < MW; j++) begin : g_sqrt
		logic [MW+2:0] cur;
		logic [MW+2:0] tst;
		logic          ge;

		if (j == 0) begin : g_first
			assign rt_in[j]  = '0;
			assign sr_in[j]  = '0;
			assign rad_in[j] = nqm_pkg::RAD_W'(dq_s[QW-1]);
		end else begin : g_next
			assign rt_in[j]  = rt_s[j-1];
			assign sr_in[j]  = sr_s[j-1];
			assign rad_in[j] = rad_s[j-1];
		end

		always_comb begin
			cur = {sr_in[j], rad_in[j][nqm_pkg::RAD_W-1 -: 2]};
			tst = {1'b0, rt_in[j], 2'b01};
			ge  = (cur >= tst);
		end

		always_ff @(posedge clk) begin
			if (en[QW + j]) begin
				sr_s[j]  <= ge ? (MW + 1)'(cur - tst) : cur[MW:0];
				rt_s[j]  <= {rt_in[j][MW-2:0], ge};
				rad_s[j] <= {rad_in[j][nqm_pkg::RAD_W-3:0], 2'b00};
			end
		end
	end

	// round half up on extra root bit, apply sign; identity when S = 0
	logic [MW:0]    rnd;
	logic [MW-1:0]  mag_u;
	nqm_pkg::unit_t unit_d;
	nqm_pkg::unit_t unit_q;

	always_comb begin
		rnd   = {1'b0, rt_s[MW-1]} + (MW + 1)'(1);
		mag_u = rnd[MW:1];
		if (ctl_s[CTL_ST-1].zero) begin
			unit_d = ctl_s[CTL_ST-1].scalar ? nqm_pkg::unit_t'(1 << nqm_pkg::FRAC_BITS) : '0;
		end else if (ctl_s[CTL_ST-1].neg) begin
			unit_d = -$signed(mag_u);
		end else begin
			unit_d = $signed(mag_u);
		end
	end

	always_ff @(posedge clk) begin
		if (en[nqm_pkg::LANE_ST-1]) begin
			unit_q <= unit_d;
		end
	end

	assign unit = unit_q;

endmodule

// ===== hdl/nqm_hamilton.sv =====
// ----------------------------------------------------------------------------
// nqm_hamilton
// Merge stage: sixteen registered lane products, then the four signed sums
// with rounding to FRAC_BITS and saturation to the unit range.
// ----------------------------------------------------------------------------
module nqm_hamilton (
	input  logic           clk,
	input  logic           en_mul,
	input  logic           en_out,
	input  nqm_pkg::unit_t lq [nqm_pkg::NUM_COMP],
	input  nqm_pkg::unit_t rq [nqm_pkg::NUM_COMP],
	output nqm_pkg::comp_t prod [nqm_pkg::NUM_COMP]
);

	localparam int AW = nqm_pkg::ACC_W;

	logic signed [nqm_pkg::PW-1:0] p_s1 [nqm_pkg::NUM_COMP][nqm_pkg::NUM_COMP];

	always_ff @(posedge clk) begin
		if (en_mul) begin
			for (int i = 0; i < nqm_pkg::NUM_COMP; i++) begin
				for (int j = 0; j < nqm_pkg::NUM_COMP; j++) begin
					p_s1[i][j] <= lq[i] * rq[j];
				end
			end
		end
	end

	logic signed [AW-1:0] e [nqm_pkg::NUM_COMP][nqm_pkg::NUM_COMP];
	logic signed [AW-1:0] acc [nqm_pkg::NUM_COMP];
	logic signed [AW-1:0] shr [nqm_pkg::NUM_COMP];
	nqm_pkg::comp_t       res [nqm_pkg::NUM_COMP];

	localparam logic signed [AW-1:0] ONE  = AW'(1) <<< nqm_pkg::FRAC_BITS;
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (nqm_pkg::FRAC_BITS - 1);

	always_comb begin
		for (int i = 0; i < nqm_pkg::NUM_COMP; i++) begin
			for (int j = 0; j < nqm_pkg::NUM_COMP; j++) begin
				e[i][j] = AW'(p_s1[i][j]);
			end
		end
		acc[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
		acc[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
		acc[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
		acc[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
		for (int i = 0; i < nqm_pkg::NUM_COMP; i++) begin
			shr[i] = (acc[i] + HALF) >>> nqm_pkg::FRAC_BITS;
			if (shr[i] > ONE) begin
				res[i] = nqm_pkg::COMP_WIDTH'(ONE);
			end else if (shr[i] < -ONE) begin
				res[i] = nqm_pkg::COMP_WIDTH'(-ONE);
			end else begin
				res[i] = nqm_pkg::COMP_WIDTH'(shr[i]);
			end
		end
	end

	nqm_pkg::comp_t out_s2 [nqm_pkg::NUM_COMP];

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_s2 <= res;
		end
	end

	assign prod = out_s2;

endmodule

// ===== hdl/normalized_quaternion_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// normalized_quaternion_multiply_unit
// Normalizes two Q1.14 quaternions and returns their Hamilton product.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one quaternion pair per transaction; master stream
//   returns the product (w, x, y, z), each component saturated to +/-1.0.
//   Eight lanes normalize the eight input components side by side: each lane
//   runs a restoring divider (one quotient bit per stage, 2F+3 stages) and a
//   bit-serial square root (one root bit per stage, F+2 stages). Throughput
//   is one transaction per cycle unless the receiver stalls; every stage is
//   registered and holds its own valid bit, so empty stages fill while the
//   output waits. When the receiver stalls, the output holds and stages
//   behind it advance until they are full; s_tready then drops.
//   An all-zero quaternion is taken as the identity.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module normalized_quaternion_multiply_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// left_w, left_x, left_y, left_z, right_w, right_x, right_y, right_z
	input  logic [nqm_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// prod_w, prod_x, prod_y, prod_z
	output logic [nqm_pkg::OUT_DATA_W-1:0]     m_tdata
);

	localparam int CW = nqm_pkg::COMP_WIDTH;
	localparam int NL = nqm_pkg::NUM_LANE;
	localparam int NC = nqm_pkg::NUM_COMP;
	localparam int LAST = nqm_pkg::PIPE_ST - 1;

	// stage valids and enables; a stage advances when empty or drained
	logic [nqm_pkg::PIPE_ST-1:0] v_q;
	logic [nqm_pkg::PIPE_ST-1:0] en;

	always_comb begin
		en[LAST] = !v_q[LAST] || m_tready;
		for (int k = LAST - 1; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int k = 1; k < nqm_pkg::PIPE_ST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = v_q[LAST];

	// magnitudes and signs
	nqm_pkg::comp_t comp [NL];
	nqm_pkg::comp_t mag_s1 [NL];
	logic           neg_s1 [NL];

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			comp[i] = s_tdata[i*CW +: CW];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NL; i++) begin
				neg_s1[i] <= comp[i][CW-1];
				mag_s1[i] <= comp[i][CW-1] ? -comp[i] : comp[i];
			end
		end
	end

	// squares
	logic [nqm_pkg::SQ_W-1:0] sq_s2 [NL];
	logic                     neg_s2 [NL];
	logic [2*CW-1:0]          sq_full [NL];

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			sq_full[i] = mag_s1[i] * mag_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < NL; i++) begin
				sq_s2[i]  <= sq_full[i][nqm_pkg::SQ_W-1:0];
				neg_s2[i] <= neg_s1[i];
			end
		end
	end

	// sum of squares per quaternion
	logic [nqm_pkg::SQ_W-1:0] sq_s3 [NL];
	logic                     neg_s3 [NL];
	logic [nqm_pkg::S_W-1:0]  sum_s3 [2];
	logic [nqm_pkg::S_W-1:0]  sum_d [2];

	always_comb begin
		for (int q = 0; q < 2; q++) begin
			sum_d[q] = nqm_pkg::S_W'(sq_s2[q*NC]) + nqm_pkg::S_W'(sq_s2[q*NC+1])
				+ nqm_pkg::S_W'(sq_s2[q*NC+2]) + nqm_pkg::S_W'(sq_s2[q*NC+3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sq_s3  <= sq_s2;
			neg_s3 <= neg_s2;
			sum_s3 <= sum_d;
		end
	end

	// normalization lanes
	nqm_pkg::unit_t unit [NL];

	for (genvar i = 0; i < NL; i++) begin : g_lane
		nqm_pkg::lane_ctl_t ctl;

		always_comb begin
			ctl.neg    = neg_s3[i];
			ctl.zero   = (sum_s3[i/NC] == '0);
			ctl.scalar = ((i % NC) == 0);
		end

		nqm_norm_lane u_lane (
			.clk    (clk),
			.en     (en[3 +: nqm_pkg::LANE_ST]),
			.sq_in  (sq_s3[i]),
			.sum_in (sum_s3[i/NC]),
			.ctl_in (ctl),
			.unit   (unit[i])
		);
	end

	// Hamilton product
	nqm_pkg::unit_t lq [NC];
	nqm_pkg::unit_t rq [NC];
	nqm_pkg::comp_t prod [NC];

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			lq[i] = unit[i];
			rq[i] = unit[NC + i];
		end
	end

	nqm_hamilton u_ham (
		.clk    (clk),
		.en_mul (en[LAST-1]),
		.en_out (en[LAST]),
		.lq     (lq),
		.rq     (rq),
		.prod   (prod)
	);

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < NC; i++) begin
			m_tdata[i*CW +: CW] = prod[i];
		end
	end

endmodule

// ===== hdl/nqm_checker.sv =====
// ----------------------------------------------------------------------------
// nqm_checker
// Port-level checks for the normalized quaternion multiply unit.
// ----------------------------------------------------------------------------
module nqm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [nqm_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int CW = nqm_pkg::COMP_WIDTH;
	localparam logic signed [CW-1:0] ONE = CW'(1 << nqm_pkg::FRAC_BITS);

	logic in_range;

	always_comb begin
		in_range = 1'b1;
		for (int i = 0; i < nqm_pkg::NUM_COMP; i++) begin
			if ($signed(m_tdata[i*CW +: CW]) > ONE || $signed(m_tdata[i*CW +: CW]) < -ONE) begin
				in_range = 1'b0;
			end
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> in_range)
		else $error("product component outside unit range");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid after reset");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind normalized_quaternion_multiply_unit nqm_checker u_nqm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb_normalized_quaternion_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// tb_normalized_quaternion_multiply_unit
// Drives quaternion pairs through the unit and checks each product against
// an exact integer model of normalization, Hamilton product and saturation.
// ----------------------------------------------------------------------------
module tb_normalized_quaternion_multiply_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB     = nqm_pkg::FRAC_BITS;
	localparam int CW     = nqm_pkg::COMP_WIDTH;
	localparam int NC     = nqm_pkg::NUM_COMP;
	localparam int IN_DW  = nqm_pkg::IN_DATA_W;
	localparam int OUT_DW = nqm_pkg::OUT_DATA_W;

	localparam int RAND_PAIRS = 1150;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int NUM_ROWS = 12;

	typedef logic signed [CW-1:0] scomp_t;
	typedef scomp_t quat_t [NC];

	typedef struct {
		scomp_t lq [NC];
		scomp_t rq [NC];
		logic   known;
		scomp_t pw [NC];
	} vec_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DW-1:0] m_tdata;

	logic [OUT_DW-1:0] product_q [$];
	int mismatches;
	int products_seen;
	int pairs_sent;
	longint cycles;

	normalized_quaternion_multiply_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// exact unit scaling: m = round(|c| * 2^F / sqrt(S)), halves away from zero
	function automatic void unit_scale(input scomp_t c [NC], output longint n [NC]);
		logic [127:0] sum_sq;
		logic [127:0] lhs;
		logic [127:0] rhs;
		longint mag;
		longint m;
		longint t;
		sum_sq = '0;
		for (int i = 0; i < NC; i++) begin
			mag = (c[i] < 0) ? -longint'(c[i]) : longint'(c[i]);
			sum_sq += 128'(mag * mag);
		end
		if (sum_sq == 0) begin
			n[0] = longint'(1) << FB;
			for (int i = 1; i < NC; i++) n[i] = 0;
			return;
		end
		for (int i = 0; i < NC; i++) begin
			mag = (c[i] < 0) ? -longint'(c[i]) : longint'(c[i]);
			rhs = 128'(mag * mag) << (2 * FB + 2);
			m = 0;
			for (int b = FB + 1; b >= 0; b--) begin
				t = m | (longint'(1) << b);
				lhs = 128'(t * t) * sum_sq;
				if (lhs <= rhs) m = t;
			end
			m = (m + 1) >>> 1;
			n[i] = (c[i] < 0) ? -m : m;
		end
	endfunction

	function automatic scomp_t round_sat(input longint acc);
		longint v;
		longint one;
		one = longint'(1) << FB;
		v = (acc + (longint'(1) << (FB - 1))) >>> FB;
		if (v > one) v = one;
		if (v < -one) v = -one;
		return scomp_t'(v);
	endfunction

	function automatic logic [OUT_DW-1:0] hamilton_product(input scomp_t lq [NC],
			input scomp_t rq [NC]);
		longint l [NC];
		longint r [NC];
		logic [OUT_DW-1:0] p;
		unit_scale(lq, l);
		unit_scale(rq, r);
		p = '0;
		p[0*CW +: CW] = round_sat(l[0]*r[0] - l[1]*r[1] - l[2]*r[2] - l[3]*r[3]);
		p[1*CW +: CW] = round_sat(l[0]*r[1] + l[1]*r[0] + l[2]*r[3] - l[3]*r[2]);
		p[2*CW +: CW] = round_sat(l[0]*r[2] - l[1]*r[3] + l[2]*r[0] + l[3]*r[1]);
		p[3*CW +: CW] = round_sat(l[0]*r[3] + l[1]*r[2] - l[2]*r[1] + l[3]*r[0]);
		return p;
	endfunction

	function automatic logic [IN_DW-1:0] pack_pair(input scomp_t lq [NC],
			input scomp_t rq [NC]);
		logic [IN_DW-1:0] d;
		d = '0;
		for (int i = 0; i < NC; i++) begin
			d[i*CW +: CW] = lq[i];
			d[(NC+i)*CW +: CW] = rq[i];
		end
		return d;
	endfunction

	task automatic report_mismatch(input string what, input int comp, input scomp_t got,
			input scomp_t want);
		$display("mismatch %s comp %0d got %0d want %0d at %0t", what, comp,
			got, want, $realtime);
		mismatches++;
	endtask

	// one transaction, held until accepted
	task automatic send_pair(input scomp_t lq [NC], input scomp_t rq [NC]);
		s_tvalid <= 1'b1;
		s_tdata <= pack_pair(lq, rq);
		do @(posedge clk); while (!s_tready);
		product_q.push_back(hamilton_product(lq, rq));
		pairs_sent++;
	endtask

	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic scomp_t rand_comp();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return scomp_t'($urandom_range(0, 7)) - 16'sd3;
			4: return 16'sh4000;
			default: return scomp_t'($urandom);
		endcase
	endfunction

	// receiver stall pattern and output checking
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (product_q.size() == 0) begin
				$display("unexpected product %h at %0t", m_tdata, $realtime);
				mismatches++;
			end else begin
				logic [OUT_DW-1:0] want;
				want = product_q.pop_front();
				for (int i = 0; i < NC; i++)
					if (m_tdata[i*CW +: CW] != want[i*CW +: CW])
						report_mismatch("product", i, m_tdata[i*CW +: CW],
							want[i*CW +: CW]);
			end
			products_seen++;
		end
		if (arst_n) begin
			// alternate long open stretches with choppy stalls
			if ((cycles / 500) % 3 == 0) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d products outstanding", cycles,
				product_q.size());
			$display("FAIL normalized_quaternion_multiply_unit");
			$finish;
		end
	end

	vec_t table_rows [NUM_ROWS] = '{
		'{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
			1'b1, '{16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000}},
		'{'{16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000}, '{16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000},
			1'b1, '{16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000}},
		'{'{16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000}, '{16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000},
			1'b1, '{-16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000}},
		'{'{16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000}, '{16'sh0000, 16'sh0000, 16'sh4000, 16'sh0000},
			1'b1, '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000}},
		'{'{16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000}, '{16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000},
			1'b1, '{-16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000}},
		'{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
			1'b0, '{16'sh0, 16'sh0, 16'sh0, 16'sh0}},
		'{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000},
			1'b0, '{16'sh0, 16'sh0, 16'sh0, 16'sh0}},
		'{'{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000}, '{16'sh0000, 16'sh0000, 16'sh0000, 16'shffff},
			1'b1, '{16'sh0000, 16'sh0000, 16'sh0000, -16'sh4000}},
		'{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000}, '{16'sh1234, -16'sh0567, 16'sh2abc, 16'sh7fff},
			1'b0, '{16'sh0, 16'sh0, 16'sh0, 16'sh0}},
		'{'{16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001}, '{16'shffff, 16'sh0001, 16'shffff, 16'sh0001},
			1'b0, '{16'sh0, 16'sh0, 16'sh0, 16'sh0}},
		'{'{16'sh5555, 16'shaaaa, 16'sh0f0f, 16'shf0f0}, '{16'shaaaa, 16'sh5555, 16'shf0f0, 16'sh0f0f},
			1'b0, '{16'sh0, 16'sh0, 16'sh0, 16'sh0}},
		'{'{16'sh0003, 16'sh0004, 16'sh0000, 16'sh0000}, '{16'sh0000, 16'sh0000, 16'sh0003, 16'sh0004},
			1'b0, '{16'sh0, 16'sh0, 16'sh0, 16'sh0}}
	};

	initial begin
		quat_t lq;
		quat_t rq;
		logic [OUT_DW-1:0] typed;
		int wait_cycles;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		products_seen = 0;
		pairs_sent = 0;
		cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: where a product is typed in, cross-check the model too
		foreach (table_rows[k]) begin
			lq = table_rows[k].lq;
			rq = table_rows[k].rq;
			if (table_rows[k].known) begin
				typed = '0;
				for (int i = 0; i < NC; i++)
					typed[i*CW +: CW] = table_rows[k].pw[i];
				if (typed != hamilton_product(lq, rq)) begin
					$display("table row %0d disagrees with predictor", k);
					mismatches++;
				end
			end
			send_pair(lq, rq);
			idle_gap();
		end

		for (int k = 0; k < RAND_PAIRS; k++) begin
			for (int i = 0; i < NC; i++) begin
				lq[i] = rand_comp();
				rq[i] = rand_comp();
			end
			// occasionally zero one whole side
			if ($urandom_range(0, 19) == 0)
				for (int i = 0; i < NC; i++) lq[i] = '0;
			if ($urandom_range(0, 19) == 0)
				for (int i = 0; i < NC; i++) rq[i] = '0;
			send_pair(lq, rq);
			idle_gap();
		end
		s_tvalid <= 1'b0;

		while (product_q.size() != 0) @(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < DRAIN_CYCLES) begin
			@(posedge clk);
			wait_cycles++;
		end

		$display("sent %0d quaternion pairs, checked %0d products", pairs_sent, products_seen);
		$display("covered zero, extreme and unit-axis components under random stalls");
		if (mismatches == 0) begin
			$display("PASS normalized_quaternion_multiply_unit");
		end else begin
			$display("FAIL normalized_quaternion_multiply_unit");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/nqm_pkg.sv
hdl/nqm_norm_lane.sv
hdl/nqm_hamilton.sv
hdl/normalized_quaternion_multiply_unit.sv
hdl/nqm_checker.sv
tb/tb_normalized_quaternion_multiply_unit.sv
